/* sv/dbcs_pkg.sv */
// shared types and constants for the dbcs to utf-16 decoder
package dbcs_pkg;

    localparam int RANGE_REGS  = 4;
    localparam int TABLE_DEPTH = 65536;
    localparam int TABLE_AW    = 16;
    localparam int UNIT_W      = 16;
    localparam int OUTQ_DEPTH  = 3;

    localparam logic [7:0]        RANGE_END = 8'h00;
    localparam logic [UNIT_W-1:0] UNIT_NONE = 16'h0000;

    typedef enum logic {
        FUNC_DECODE = 1'b0,
        FUNC_WRITE  = 1'b1
    } t_func;

    // table access issued by the front end for an accepted item
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [TABLE_AW-1:0]  addr;
        logic [UNIT_W-1:0]    wdata;
    } t_mem_req;

endpackage

/* sv/dbcs_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module dbcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/dbcs_front.sv */
// lead-byte ranges, held lead state and table address forming
module dbcs_front #(
    parameter int LEAD_RANGES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata,
    output logic [15:0]       o_cfg_rdata,
    input  logic              i_accept,
    input  dbcs_pkg::t_func   i_func,
    input  logic [7:0]        i_data_byte,
    input  logic [15:0]       i_table_index,
    input  logic [15:0]       i_table_value,
    output dbcs_pkg::t_mem_req o_req
);

    localparam int SCAN = (LEAD_RANGES < dbcs_pkg::RANGE_REGS) ?
                          LEAD_RANGES : dbcs_pkg::RANGE_REGS;

    logic [15:0] r_range [dbcs_pkg::RANGE_REGS];
    logic        r_pending, n_pending;
    logic [7:0]  r_held, n_held;
    logic        is_lead;
    logic        alive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dbcs_pkg::RANGE_REGS; i++) begin
                r_range[i] <= 16'h0000;
            end
        end else if (i_cfg_we) begin
            r_range[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    assign o_cfg_rdata = r_range[i_cfg_idx];

    // ranges scanned in order, a zero low bound ends the list
    always_comb begin
        is_lead = 1'b0;
        alive   = 1'b1;
        for (int i = 0; i < SCAN; i++) begin
            if (r_range[i][7:0] == dbcs_pkg::RANGE_END) begin
                alive = 1'b0;
            end
            if (alive && (r_range[i][7:0] <= i_data_byte) &&
                (i_data_byte <= r_range[i][15:8])) begin
                is_lead = 1'b1;
            end
        end
    end

    always_comb begin
        n_pending  = r_pending;
        n_held     = r_held;
        o_req.we    = 1'b0;
        o_req.re    = 1'b0;
        o_req.addr  = i_table_index;
        o_req.wdata = i_table_value;
        if (i_accept) begin
            case (i_func)
                dbcs_pkg::FUNC_WRITE: begin
                    o_req.we = 1'b1;
                end
                dbcs_pkg::FUNC_DECODE: begin
                    if (r_pending) begin
                        o_req.re   = 1'b1;
                        o_req.addr = {r_held, i_data_byte};
                        n_pending  = 1'b0;
                        n_held     = 8'h00;
                    end else if (is_lead) begin
                        n_pending = 1'b1;
                        n_held    = i_data_byte;
                    end else begin
                        o_req.re   = 1'b1;
                        o_req.addr = {8'h00, i_data_byte};
                    end
                end
                default: begin
                    o_req.we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= 8'h00;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

/* sv/dbcs_outq.sv */
// small result queue between the table read and the output channel
module dbcs_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [dbcs_pkg::UNIT_W-1:0] i_push_data,
    input  logic                        i_pop,
    output logic                        o_valid,
    output logic [dbcs_pkg::UNIT_W-1:0] o_data,
    output logic [1:0]                  o_count
);

    localparam logic [1:0] LAST = 2'(dbcs_pkg::OUTQ_DEPTH - 1);

    logic [dbcs_pkg::UNIT_W-1:0] r_buf [dbcs_pkg::OUTQ_DEPTH];
    logic [1:0] r_wp, r_rp, r_cnt;
    logic [1:0] n_wp, n_rp, n_cnt;
    logic       do_pop;

    assign do_pop = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST) ? 2'd0 : r_wp + 2'd1;
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST) ? 2'd0 : r_rp + 2'd1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];
    assign o_count = r_cnt;

endmodule

/* sv/dbcs_to_utf16_decoder.sv */
// top level of the dbcs byte stream to utf-16 decoder
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+------------------------------------
//  s_        | in        | s_tvalid / s_tready  | tdata: byte, index, value; tuser: func
//  m_        | out       | m_tvalid / m_tready  | tdata: code unit; tuser: invalid
//  apb       | in        | psel/penable/pready  | four lead range registers
//
// one item per cycle while s_tready is high; a decoded unit is registered in the
// table ram read and then held in the result queue before it leaves on m_
// the held lead byte is a registered loop in flip-flops, the table is one ram
// s_tready depends on registers only and drops when three results are queued
// or in the ram read stage; reset is synchronous, the table is not cleared

module dbcs_to_utf16_decoder #(
    parameter int LEAD_RANGES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [23:8] table_index, [39:24] table_value
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tuser,   // [0] invalid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dbcs_pkg::t_mem_req mem_req;
    dbcs_pkg::t_func    func;
    logic [15:0]        cfg_rdata;
    logic               accept;
    logic               cfg_we;
    logic               r_s1_vld;
    logic [15:0]        ram_rdata;
    logic [1:0]         q_count;
    logic [2:0]         in_flight;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign prdata   = {16'h0000, cfg_rdata};
    assign func     = dbcs_pkg::t_func'(s_tuser);

    assign in_flight = {1'b0, q_count} + {2'b00, r_s1_vld};
    assign s_tready  = (in_flight < 3'(dbcs_pkg::OUTQ_DEPTH));
    assign accept    = s_tvalid && s_tready;

    dbcs_front #(
        .LEAD_RANGES (LEAD_RANGES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (paddr[3:2]),
        .i_cfg_wdata   (pwdata[15:0]),
        .o_cfg_rdata   (cfg_rdata),
        .i_accept      (accept),
        .i_func        (func),
        .i_data_byte   (s_tdata[7:0]),
        .i_table_index (s_tdata[23:8]),
        .i_table_value (s_tdata[39:24]),
        .o_req         (mem_req)
    );

    dbcs_ram #(
        .WIDTH (dbcs_pkg::UNIT_W),
        .DEPTH (dbcs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= mem_req.re;
        end
    end

    dbcs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_vld),
        .i_push_data (ram_rdata),
        .i_pop       (m_tready),
        .o_valid     (m_tvalid),
        .o_data      (m_tdata),
        .o_count     (q_count)
    );

    assign m_tuser = (m_tdata == dbcs_pkg::UNIT_NONE);

endmodule

/* sv/dbcs_checker.sv */
// port-level checks for the dbcs decoder, bound to the top level
module dbcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        pready
);

    // the invalid flag marks exactly the zero code unit
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == (m_tdata == 16'h0000)))
        else $error("invalid flag does not match code unit");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output transfer changed while stalled");

    // input only stalls while results back up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending output");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind dbcs_to_utf16_decoder dbcs_checker u_dbcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
